### rtl/core/altm_pkg.sv
// ----------------------------------------------------------------------------
// ACES luma tone map package
// Fixed-point coefficients and register defaults shared by the tone mapper.
// ----------------------------------------------------------------------------
package altm_pkg;

  // Default channel format: integer and fraction bits
  localparam int unsigned DefIntBits  = 12;
  localparam int unsigned DefFracBits = 8;

  // Rec.709 luma weights, Q0.16 (sum is one)
  localparam logic [15:0] LumaR = 16'd13933;
  localparam logic [15:0] LumaG = 16'd46871;
  localparam logic [15:0] LumaB = 16'd4732;

  // Display white in channel units before the fraction shift
  localparam logic [8:0] White = 9'd255;

  // Rational fit coefficients, Q16
  localparam logic [17:0] FitA1 = 18'd164495;
  localparam logic [17:0] FitA0 = 18'd1966;
  localparam logic [17:0] FitB1 = 18'd159252;
  localparam logic [17:0] FitB0 = 18'd38666;
  localparam logic [17:0] FitC0 = 18'd9175;

  // Unity in Q16 and reset value of the blend weight
  localparam logic [16:0] OneQ16        = 17'd65536;
  localparam logic [16:0] BlendStrReset = 17'd65536;

endpackage

### rtl/core/aces_luma_tone_map.sv
// ----------------------------------------------------------------------------
// ACES luma tone map
// Luma-preserving filmic tone mapper: one RGB pixel in, one RGB pixel out.
// ----------------------------------------------------------------------------
// The latency from an accepted input item to its output item is the same at any width.
// Throughput: one item per cycle; the stages advance together unless the
//   output register holds an item that is not taken.
// The variable divides run as restoring dividers, one quotient bit per stage;
//   the fixed divide by white is a reciprocal multiply in one stage.
// Reset clears all valid bits and loads the blend weight with one.
module aces_luma_tone_map #(
  parameter int unsigned CHANNEL_INT_BITS  = altm_pkg::DefIntBits,
  parameter int unsigned CHANNEL_FRAC_BITS = altm_pkg::DefFracBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // blend weight, Q1.16
  input  logic                  cfg_we_i,
  input  logic [16:0]           cfg_wdata_i,
  // tdata: red_in, green_in, blue_in, zero fill
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [((3*(CHANNEL_INT_BITS+CHANNEL_FRAC_BITS)+7)/8)*8-1:0] s_axis_tdata,
  // tdata: red_out, green_out, blue_out, zero fill
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [((3*(CHANNEL_INT_BITS+CHANNEL_FRAC_BITS)+7)/8)*8-1:0] m_axis_tdata
);
  import altm_pkg::*;

  localparam int unsigned CW  = CHANNEL_INT_BITS + CHANNEL_FRAC_BITS;
  localparam int unsigned FB  = CHANNEL_FRAC_BITS;
  localparam int unsigned DW  = ((3 * CW + 7) / 8) * 8;
  localparam int unsigned LW  = CW + 16;
  localparam int unsigned YW  = LW + 1 - FB;
  localparam int unsigned XK  = YW + 8;
  localparam int unsigned XW  = CHANNEL_INT_BITS + 9;
  localparam int unsigned AW  = XW + 2;
  localparam int unsigned PW  = 2 * XW + 3;
  localparam int unsigned VW  = CW + 17;

  // Reciprocal of white, exact floor for every luma value
  localparam logic [YW:0] XRecip = (YW+1)'(((64'd1 << XK) + 64'd254) / 64'd255);

  // Stage map
  localparam int unsigned StLsum = 1;
  localparam int unsigned StXd   = 2;
  localparam int unsigned StAb   = StXd + 1;
  localparam int unsigned StNd   = StAb + 1;
  localparam int unsigned StMc   = StNd + 1;
  localparam int unsigned StMd0  = StMc + 1;
  localparam int unsigned StVm   = StMd0 + 16;
  localparam int unsigned StTc   = StVm + 1;
  localparam int unsigned StTd0  = StTc + 1;
  localparam int unsigned StMap  = StTd0 + 16;
  localparam int unsigned StMix  = StMap + 1;
  localparam int unsigned StOut  = StMix + 1;
  localparam int unsigned NSt    = StOut + 1;

  typedef struct packed {
    logic [2:0][CW-1:0] ch;
    logic [LW-1:0]      lsum;
    logic [YW-1:0]      y;
    logic [XW-1:0]      xq;
    logic [AW-1:0]      fa;
    logic [AW-1:0]      fb;
    logic [PW-1:0]      num;
    logic [PW-1:0]      den;
    logic               msat;
    logic [PW:0]        mr;
    logic [15:0]        mq;
    logic [2:0][VW-1:0] vm;
    logic               lz;
    logic [2:0]         tsat;
    logic [2:0][LW:0]   tr;
    logic [2:0][15:0]   tq;
    logic [2:0][CW-1:0] mc;
    logic [2:0][VW-1:0] pa;
    logic [2:0][VW-1:0] pb;
    logic [2:0][CW-1:0] res;
  } pipe_t;

  pipe_t           p_q   [NSt];
  pipe_t           p_d   [NSt];
  logic [NSt-1:0]  vld_q;
  logic            adv;
  logic [16:0]     blend_q;
  logic [16:0]     str;

  // Hold the blend weight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_q <= BlendStrReset;
    end else if (cfg_we_i) begin
      blend_q <= cfg_wdata_i;
    end
  end

  assign str = (blend_q > OneQ16) ? OneQ16 : blend_q;

  // Advance all stages unless the output item is stalled
  assign adv           = !vld_q[NSt-1] || m_axis_tready;
  assign s_axis_tready = adv;

  // Capture the input pixel
  always_comb begin
    p_d[0]    = p_q[0];
    p_d[0].ch = {s_axis_tdata[3*CW-1:2*CW], s_axis_tdata[2*CW-1:CW], s_axis_tdata[CW-1:0]};
  end

  for (genvar g = 1; g < NSt; g++) begin : g_st
    if (g == StLsum) begin : g_lsum
      // Form the luma sum and pre-round for the divide by white
      always_comb begin
        logic [LW:0] sum;
        p_d[g] = p_q[g-1];
        sum = (LW+1)'(LumaR) * (LW+1)'(p_q[g-1].ch[0])
            + (LW+1)'(LumaG) * (LW+1)'(p_q[g-1].ch[1])
            + (LW+1)'(LumaB) * (LW+1)'(p_q[g-1].ch[2]);
        p_d[g].lsum = sum[LW-1:0];
        sum = sum + ((LW+1)'(White) << (FB - 1));
        p_d[g].y  = YW'(sum >> FB);
        p_d[g].xq = '0;
      end
    end else if (g == StXd) begin : g_xd
      // Divide by white through the reciprocal
      always_comb begin
        logic [2*YW:0] pr;
        p_d[g] = p_q[g-1];
        pr = (2*YW+1)'(p_q[g-1].y) * (2*YW+1)'(XRecip);
        p_d[g].xq = XW'(pr >> XK);
      end
    end else if (g == StAb) begin : g_ab
      // Linear terms of the fit
      always_comb begin
        logic [XW+19:0] ta;
        logic [XW+19:0] tb;
        logic [XW-1:0]  xv;
        p_d[g] = p_q[g-1];
        xv = p_q[g-1].xq[XW-1:0];
        ta = (XW+20)'(FitA1) * (XW+20)'(xv) + ((XW+20)'(FitA0) << 16);
        tb = (XW+20)'(FitB1) * (XW+20)'(xv) + ((XW+20)'(FitB0) << 16);
        p_d[g].fa = AW'(ta >> 16);
        p_d[g].fb = AW'(tb >> 16);
      end
    end else if (g == StNd) begin : g_nd
      // Numerator and denominator of the fit
      always_comb begin
        logic [XW-1:0] xv;
        p_d[g] = p_q[g-1];
        xv = p_q[g-1].xq[XW-1:0];
        p_d[g].num = PW'(xv) * PW'(p_q[g-1].fa);
        p_d[g].den = PW'(xv) * PW'(p_q[g-1].fb) + (PW'(FitC0) << 16);
      end
    end else if (g == StMc) begin : g_mc
      // Saturate the fit at one
      always_comb begin
        p_d[g] = p_q[g-1];
        p_d[g].msat = p_q[g-1].num >= p_q[g-1].den;
        p_d[g].mr   = (PW+1)'(p_q[g-1].num);
        p_d[g].mq   = '0;
      end
    end else if (g >= StMd0 && g < StVm) begin : g_md
      // Fit ratio, one quotient bit
      always_comb begin
        logic [PW+1:0] r;
        p_d[g] = p_q[g-1];
        r = {p_q[g-1].mr, 1'b0};
        p_d[g].mq = {p_q[g-1].mq[14:0], 1'b0};
        if (r >= (PW+2)'(p_q[g-1].den)) begin
          r = r - (PW+2)'(p_q[g-1].den);
          p_d[g].mq[0] = 1'b1;
        end
        p_d[g].mr = r[PW:0];
      end
    end else if (g == StVm) begin : g_vm
      // Scale each channel by the mapped luma
      always_comb begin
        logic [16:0] mv;
        p_d[g] = p_q[g-1];
        mv = p_q[g-1].msat ? OneQ16 : {1'b0, p_q[g-1].mq};
        for (int c = 0; c < 3; c++) begin
          p_d[g].vm[c] = VW'(p_q[g-1].ch[c]) * VW'(mv);
        end
      end
    end else if (g == StTc) begin : g_tc
      // Saturate each channel ratio at one
      always_comb begin
        p_d[g] = p_q[g-1];
        p_d[g].lz = p_q[g-1].lsum == '0;
        for (int c = 0; c < 3; c++) begin
          p_d[g].tsat[c] = p_q[g-1].vm[c] >= VW'(p_q[g-1].lsum);
          p_d[g].tr[c]   = (LW+1)'(p_q[g-1].vm[c]);
          p_d[g].tq[c]   = '0;
        end
      end
    end else if (g >= StTd0 && g < StMap) begin : g_td
      // Channel ratios over luma, one quotient bit each
      always_comb begin
        logic [LW+1:0] r;
        p_d[g] = p_q[g-1];
        for (int c = 0; c < 3; c++) begin
          r = {p_q[g-1].tr[c], 1'b0};
          p_d[g].tq[c] = {p_q[g-1].tq[c][14:0], 1'b0};
          if (r >= (LW+2)'(p_q[g-1].lsum)) begin
            r = r - (LW+2)'(p_q[g-1].lsum);
            p_d[g].tq[c][0] = 1'b1;
          end
          p_d[g].tr[c] = r[LW:0];
        end
      end
    end else if (g == StMap) begin : g_map
      // Rescale the ratio to channel units
      always_comb begin
        logic [16:0]   tv;
        logic [FB+26:0] tm;
        p_d[g] = p_q[g-1];
        for (int c = 0; c < 3; c++) begin
          tv = p_q[g-1].lz ? 17'd0 : (p_q[g-1].tsat[c] ? OneQ16 : {1'b0, p_q[g-1].tq[c]});
          tm = (((FB+27)'(tv) << 8) - (FB+27)'(tv)) << FB;
          tm = tm + (FB+27)'(32768);
          p_d[g].mc[c] = CW'(tm >> 16);
        end
      end
    end else if (g == StMix) begin : g_mix
      // Weight the original and mapped colors
      always_comb begin
        p_d[g] = p_q[g-1];
        for (int c = 0; c < 3; c++) begin
          p_d[g].pa[c] = VW'(p_q[g-1].ch[c]) * VW'(OneQ16 - str);
          p_d[g].pb[c] = VW'(p_q[g-1].mc[c]) * VW'(str);
        end
      end
    end else begin : g_out
      // Sum and round the blend
      always_comb begin
        logic [VW:0] sm;
        p_d[g] = p_q[g-1];
        for (int c = 0; c < 3; c++) begin
          sm = (VW+1)'(p_q[g-1].pa[c]) + (VW+1)'(p_q[g-1].pb[c]) + (VW+1)'(32768);
          p_d[g].res[c] = CW'(sm >> 16);
        end
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NSt; i++) begin
        p_q[i] <= p_d[i];
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSt-2:0], s_axis_tvalid};
    end
  end

  assign m_axis_tvalid = vld_q[NSt-1];
  assign m_axis_tdata  = DW'({p_q[NSt-1].res[2], p_q[NSt-1].res[1], p_q[NSt-1].res[0]});

  // An accepted item enters the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted item lost at pipeline entry");

  // An item one stage from the end reaches the output when the pipe advances
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && vld_q[NSt-2] |=> m_axis_tvalid)
    else $error("item lost before the output stage");

  // A stalled output stalls the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(vld_q))
    else $error("pipeline moved during an output stall");

endmodule
